// ===== rtl/gss_pkg.sv =====
// grid_stencil_sweep package: payload structs, mode codes, coefficients
// no dependencies
package gss_pkg;

	localparam int MaxCols    = 1024;
	localparam int ValueWidth = 32;
	localparam int RowsMax    = 65536;

	localparam logic [1:0] ModeHeat = 2'd0;
	localparam logic [1:0] ModeNine = 2'd1;
	localparam logic [1:0] ModeLife = 2'd2;
	localparam logic [1:0] ModeThru = 2'd3;

	localparam logic [1:0] RegMode = 2'd0;
	localparam logic [1:0] RegCols = 2'd1;
	localparam logic [1:0] RegRows = 2'd2;

	// Q16.16 coefficients
	localparam int CoefHeat   = 8192;
	localparam int CoefCenter = 62915;
	localparam int CoefEdge   = 334;
	localparam int CoefCorner = 321;

	typedef struct packed {
		logic signed [ValueWidth-1:0] cell_value;
		logic                         first_cell;
	} in_item_t;

	typedef struct packed {
		logic signed [ValueWidth-1:0] new_value;
		logic [15:0]                  out_row;
		logic [9:0]                   out_col;
		logic                         last_cell;
	} out_item_t;

endpackage

// ===== rtl/grid_stencil_sweep_top.sv =====
// grid_stencil_sweep_top: line stores, window cell chain, counters, output stage
// depends on gss_pkg, gss_col_cell, gss_calc
//
// Usage: cells of a padded grid arrive row-major on the input channel
// (in_valid/in_stall, payload in), one per item; first_cell marks the
// top-left halo cell. Each interior cell yields one item on the output
// channel (out_valid/out_stall) with its row, column and a last flag.
// Throughput is one item per cycle while the pipeline does not stall. The line
// stores are read at the accepting edge; the window shift, the product stage
// and the output register follow in that order, each of them registered.
// The pipeline advances as a whole: it stalls only while the output
// register holds an item that the receiver stalls and stage two is full,
// so a new item is taken while a result waits. Reset clears the
// counters, the window and the valid flags; line stores are not cleared
// and need no clearing pass. Configuration (cfg_we, cfg_idx, cfg_data)
// is written only while idle, as the user must ensure; the block does not enforce it.
module grid_stencil_sweep_top #(
	parameter int MAX_COLS = gss_pkg::MaxCols
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gss_pkg::in_item_t  in,
	output logic               out_valid,
	input  logic               out_stall,
	output gss_pkg::out_item_t out,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [16:0]        cfg_data
);
	localparam int Depth = MAX_COLS + 2;
	localparam int AdrW  = $clog2(Depth);
	localparam int W     = gss_pkg::ValueWidth;

	logic [1:0]  mode_q;
	logic [10:0] cols_q;
	logic [16:0] rows_q;
	logic [16:0] row_q;
	logic [10:0] col_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gss_pkg::ModeHeat;
			cols_q <= 11'd1024;
			rows_q <= 17'd1024;
		end else if (cfg_we) begin
			case (cfg_idx)
				gss_pkg::RegMode: mode_q <= cfg_data[1:0];
				gss_pkg::RegCols: cols_q <= cfg_data[10:0];
				gss_pkg::RegRows: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes, saturated
	logic [13:0] cols_e, w_pad;
	logic [17:0] rows_e, h_pad;
	always_comb begin
		cols_e = (cols_q == '0) ? 14'd1 : (14'(cols_q) > 14'(MAX_COLS)) ? 14'(MAX_COLS)
			: 14'(cols_q);
		rows_e = (rows_q == '0) ? 18'd1
			: (18'(rows_q) > 18'(gss_pkg::RowsMax)) ? 18'(gss_pkg::RowsMax)
			: 18'(rows_q);
		w_pad  = cols_e + 14'd2;
		h_pad  = rows_e + 18'd2;
	end

	// pipeline control
	logic v_s1, v_s2, adv;
	logic out_v_q;
	assign adv      = !(out_v_q && out_stall && v_s2);
	assign in_stall = !adv;
	logic acc_in;
	assign acc_in = in_valid && adv;

	// position of this item
	logic [16:0] r0;
	logic [10:0] c0;
	logic [17:0] r_t;
	logic [13:0] c_t;
	always_comb begin
		r_t = in.first_cell ? '0 : 18'(row_q);
		c_t = in.first_cell ? '0 : 14'(col_q);
		if (c_t >= w_pad) begin
			c_t = '0;
			r_t = r_t + 18'd1;
		end
		if (r_t >= h_pad) r_t = '0;
		r0 = r_t[16:0];
		c0 = c_t[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc_in) begin
			if (14'(c0) + 14'd1 >= w_pad) begin
				col_q <= '0;
				row_q <= (18'(r0) + 18'd1 >= h_pad) ? '0 : r0 + 17'd1;
			end else begin
				col_q <= c0 + 11'd1;
			end
		end
	end

	// line stores, read old and write new at the same column
	logic [W-1:0] up_mem [Depth];
	logic [W-1:0] mid_mem [Depth];
	logic [W-1:0] up_rd_s1, mid_rd_s1, cur_s1;
	logic [AdrW-1:0] adr;
	assign adr = AdrW'(c0);
	always_ff @(posedge clk) begin
		if (acc_in) begin
			up_rd_s1  <= up_mem[adr];
			mid_rd_s1 <= mid_mem[adr];
			up_mem[adr]  <= mid_mem[adr];
			mid_mem[adr] <= in.cell_value[W-1:0];
			cur_s1 <= in.cell_value[W-1:0];
		end
	end

	logic        emit_s1;
	logic [15:0] orow_s1;
	logic [9:0]  ocol_s1;
	logic        last_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			emit_s1 <= in_valid && r0 >= 17'd2 && c0 >= 11'd2;
		end
	end
	always_ff @(posedge clk) begin
		if (acc_in) begin
			orow_s1 <= 16'(r0 - 17'd2);
			ocol_s1 <= 10'(c0 - 11'd2);
			last_s1 <= (18'(r0) == rows_e + 18'd1) && (14'(c0) == cols_e + 14'd1);
		end
	end

	// window chain: right column is fed from the stores and the current cell, cells shift left
	logic [W-1:0] wu [3], wm [3], wl [3];
	logic wadv;
	assign wadv = adv && v_s1;
	gss_col_cell #(.W(W)) u_right (.clk, .arst_n, .adv(wadv),
		.up_in(up_rd_s1), .mid_in(mid_rd_s1), .low_in(cur_s1),
		.up(wu[2]), .mid(wm[2]), .low(wl[2]));
	gss_col_cell #(.W(W)) u_mid (.clk, .arst_n, .adv(wadv),
		.up_in(wu[2]), .mid_in(wm[2]), .low_in(wl[2]),
		.up(wu[1]), .mid(wm[1]), .low(wl[1]));
	gss_col_cell #(.W(W)) u_left (.clk, .arst_n, .adv(wadv),
		.up_in(wu[1]), .mid_in(wm[1]), .low_in(wl[1]),
		.up(wu[0]), .mid(wm[0]), .low(wl[0]));

	// window after this shift, as the arithmetic sees it
	logic emit_w;
	logic [15:0] orow_w;
	logic [9:0]  ocol_w;
	logic        last_w;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_w <= 1'b0;
		else if (adv) emit_w <= emit_s1 && v_s1;
	end
	always_ff @(posedge clk) begin
		if (wadv) begin
			orow_w <= orow_s1;
			ocol_w <= ocol_s1;
			last_w <= last_s1;
		end
	end

	logic signed [W-1:0] res;
	gss_calc #(.W(W)) u_calc (.clk, .en(adv), .mode(mode_q),
		.nw(wu[0]), .n(wu[1]), .ne(wu[2]), .wv(wm[0]), .c(wm[1]), .ev(wm[2]),
		.sw(wl[0]), .s(wl[1]), .se(wl[2]), .res(res));

	logic [15:0] orow_s2;
	logic [9:0]  ocol_s2;
	logic        last_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= emit_w;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			orow_s2 <= orow_w;
			ocol_s2 <= ocol_w;
			last_s2 <= last_w;
		end
	end

	// output register
	gss_pkg::out_item_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (!out_v_q || !out_stall) out_v_q <= v_s2;
	end
	always_ff @(posedge clk) begin
		if ((!out_v_q || !out_stall) && v_s2) begin
			out_q.new_value <= res;
			out_q.out_row   <= orow_s2;
			out_q.out_col   <= ocol_s2;
			out_q.last_cell <= last_s2;
		end
	end
	assign out_valid = out_v_q;
	assign out       = out_q;

	// checks
	a_no_in_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall && v_s2) |-> in_stall)
		else $error("input taken while pipeline blocked");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output item dropped");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (14'(col_q) < w_pad || cfg_we || $past(cfg_we)))
		else $error("column counter out of range");
endmodule

// ===== rtl/gss_col_cell.sv =====
// gss_col_cell: one column of the 3x3 window, shifts to its neighbor each item
// depends on nothing but its parameter
module gss_col_cell #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic [W-1:0] up_in,
	input  logic [W-1:0] mid_in,
	input  logic [W-1:0] low_in,
	output logic [W-1:0] up,
	output logic [W-1:0] mid,
	output logic [W-1:0] low
);
	// column register, loaded from its right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up  <= '0;
			mid <= '0;
			low <= '0;
		end else if (adv) begin
			up  <= up_in;
			mid <= mid_in;
			low <= low_in;
		end
	end
endmodule

// ===== rtl/gss_calc.sv =====
// gss_calc: stencil arithmetic on a 3x3 window, registered products then combinational rounding and select
// depends on gss_pkg
module gss_calc #(
	parameter int W = gss_pkg::ValueWidth
) (
	input  logic                clk,
	input  logic                en,
	input  logic [1:0]          mode,
	input  logic signed [W-1:0] nw, n, ne, wv, c, ev, sw, s, se,
	output logic signed [W-1:0] res
);
	localparam int SW = W + 3;
	localparam int AW = W + 20;
	localparam logic signed [AW-1:0] Hi = AW'((64'sd1 <<< (W - 1)) - 1);
	localparam logic signed [AW-1:0] Lo = ~Hi;

	logic signed [SW-1:0] edges, corners, ctr;
	logic signed [SW-1:0] nsum;
	logic signed [AW-1:0] acc_s1, rnd, q;
	logic [1:0]           mode_s1;
	logic signed [W-1:0]  ctr_s1;
	logic                 life1_s1;
	logic signed [W-1:0]  life_s1;

	function automatic logic life1_next(logic signed [W-1:0] cv, logic signed [SW-1:0] ns);
		if (cv == 1) return ns == 2 || ns == 3;
		return ns == 3;
	endfunction

	// sums of neighbors
	always_comb begin
		edges   = SW'(n) + SW'(s) + SW'(ev) + SW'(wv);
		corners = SW'(nw) + SW'(ne) + SW'(sw) + SW'(se);
		ctr     = SW'(c);
		nsum    = edges + corners;
	end

	// stage 1: products into an exact accumulator, life rule
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			ctr_s1  <= c;
			if (mode == gss_pkg::ModeHeat)
				acc_s1 <= AW'(32'sd8192) * AW'(edges - (ctr <<< 2))
					+ (AW'(ctr) <<< 16);
			else
				acc_s1 <= AW'(32'sd62915) * AW'(ctr) + AW'(32'sd334) * AW'(edges)
					+ AW'(32'sd321) * AW'(corners);
			life1_s1 <= (c == 1) ? (nsum == 2 || nsum == 3)
				: (c == 0 && nsum == 3);
			life_s1 <= ((c == 1) || (c == 0 && nsum == 3)) ? W'(life1_next(c, nsum)) : c;
		end
	end

	// round half up, saturate, select
	always_comb begin
		rnd = acc_s1 + AW'(32768);
		q   = rnd >>> 16;
		case (mode_s1)
			gss_pkg::ModeHeat, gss_pkg::ModeNine:
				res = (q > Hi) ? Hi[W-1:0] : (q < Lo) ? Lo[W-1:0] : q[W-1:0];
			gss_pkg::ModeLife: res = life1_s1 || (ctr_s1 == 1) || (ctr_s1 == 0)
				? life_s1 : ctr_s1;
			default: res = ctr_s1;
		endcase
	end
endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for grid_stencil_sweep_top, grids streamed in raster order
// depends on gss_pkg and the grid_stencil_sweep_top rtl
module tb;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	gss_pkg::in_item_t in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	gss_pkg::out_item_t out;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [16:0] cfg_data;

	grid_stencil_sweep_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in(in),
		.out_valid(out_valid), .out_stall(out_stall), .out(out),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow of block state
	logic [1:0] sh_mode = gss_pkg::ModeHeat;
	logic [10:0] sh_cols = 11'd1024;
	logic [16:0] sh_rows = 17'd1024;
	logic signed [31:0] row_above[gss_pkg::MaxCols+2] = '{default: '0};
	logic signed [31:0] row_mid[gss_pkg::MaxCols+2] = '{default: '0};
	logic signed [31:0] win[9] = '{default: '0};
	int unsigned pos_row = 0, pos_col = 0;

	gss_pkg::in_item_t pending_cells[$];
	gss_pkg::out_item_t expected_cells[$];
	int errors = 0;
	int checked = 0;
	int grids = 0;
	longint cycles = 0;
	bit run_active = 1;
	int in_gap = 0, out_gap = 0;

	// stall seen at the last rising edge decides acceptance
	logic in_stall_q;
	always @(posedge clk) in_stall_q <= in_stall;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
		logic signed [63:0] q;
		q = (acc + 64'sd32768) >>> 16;
		if (q > 64'sd2147483647) return 32'h7fffffff;
		if (q < -64'sd2147483648) return 32'h80000000;
		return q[31:0];
	endfunction

	// advance the shadow stencil by one cell; push the update if one is due
	task automatic predict_cell(input gss_pkg::in_item_t it);
		int unsigned w, h, r, c, cols, rows;
		logic signed [63:0] acc, nb, ctr;
		logic signed [31:0] res;
		gss_pkg::out_item_t o;
		cols = sh_cols < 1 ? 1 : (sh_cols > gss_pkg::MaxCols ? gss_pkg::MaxCols : sh_cols);
		rows = sh_rows < 1 ? 1 : (sh_rows > gss_pkg::RowsMax ? gss_pkg::RowsMax : sh_rows);
		w = cols + 2;
		h = rows + 2;
		if (it.first_cell) begin
			pos_row = 0;
			pos_col = 0;
		end
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
		end
		if (pos_row >= h) pos_row = 0;
		r = pos_row;
		c = pos_col;
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = row_above[c];
		win[5] = row_mid[c];
		row_above[c] = row_mid[c];
		row_mid[c] = it.cell_value;
		win[8] = it.cell_value;
		pos_col = c + 1;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row = (r + 1 >= h) ? 0 : r + 1;
		end
		if (r < 2 || c < 2) return;
		ctr = win[4];
		case (sh_mode)
			gss_pkg::ModeHeat: begin
				acc = 64'(gss_pkg::CoefHeat)
					* (64'(win[1]) + win[7] + win[3] + win[5] - 4 * ctr)
					+ 65536 * ctr;
				res = round_sat(acc);
			end
			gss_pkg::ModeNine: begin
				acc = 64'(gss_pkg::CoefCenter) * ctr
					+ 64'(gss_pkg::CoefEdge) * (64'(win[1]) + win[7] + win[3] + win[5])
					+ 64'(gss_pkg::CoefCorner) * (64'(win[0]) + win[2] + win[6] + win[8]);
				res = round_sat(acc);
			end
			gss_pkg::ModeLife: begin
				nb = 64'(win[0]) + win[1] + win[2] + win[3] + win[5] + win[6] + win[7]
					+ win[8];
				if (ctr == 1) res = (nb == 2 || nb == 3) ? 1 : 0;
				else if (ctr == 0 && nb == 3) res = 1;
				else res = ctr[31:0];
			end
			default: res = ctr[31:0];
		endcase
		o.new_value = res;
		o.out_row = 16'(r - 2);
		o.out_col = 10'(c - 2);
		o.last_cell = (r - 2 == rows - 1 && c - 2 == cols - 1);
		expected_cells.push_back(o);
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 25);
	endfunction

	// driver: present queued items, change at falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_q) begin
				predict_cell(in);
				void'(pending_cells.pop_front());
			end
			if (!(in_valid && in_stall_q)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (pending_cells.size() > 0) begin
					in <= pending_cells[0];
					in_valid <= 1;
					if (run_active) in_gap <= pick_gap();
				end else begin
					in_valid <= 0;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
				if (run_active) out_gap <= pick_gap();
			end
		end
	end

	// monitor: compare each accepted update with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_cells.size() == 0) begin
				$error("update with none predicted: row %0d col %0d", out.out_row, out.out_col);
				errors++;
			end else begin
				gss_pkg::out_item_t e;
				e = expected_cells.pop_front();
				if (out.new_value !== e.new_value) begin
					$error("new_value expected %0d got %0d", e.new_value, out.new_value);
					errors++;
				end
				if (out.out_row !== e.out_row) begin
					$error("out_row expected %0d got %0d", e.out_row, out.out_row);
					errors++;
				end
				if (out.out_col !== e.out_col) begin
					$error("out_col expected %0d got %0d", e.out_col, out.out_col);
					errors++;
				end
				if (out.last_cell !== e.last_cell) begin
					$error("last_cell expected %0d got %0d", e.last_cell, out.last_cell);
					errors++;
				end
				checked++;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			gss_pkg::RegMode: sh_mode = val[1:0];
			gss_pkg::RegCols: sh_cols = val[10:0];
			gss_pkg::RegRows: sh_rows = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (!(pending_cells.size() == 0 && !in_valid && expected_cells.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value(input logic [1:0] mode);
		int p;
		p = $urandom_range(0, 9);
		if (mode == gss_pkg::ModeLife)
			return (p < 8) ? 32'($urandom_range(0, 1)) : $urandom;
		if (p == 0) return 32'h7fffffff;
		if (p == 1) return 32'h80000000;
		if (p < 5) return $urandom;
		return $signed(32'($urandom_range(0, 32'h7ffff))) - 32'sh40000;
	endfunction

	// queue one full padded grid; the first cell may carry the restart mark
	task automatic queue_grid(input int cols, input int rows, input bit mark,
			input logic [1:0] mode, input int fixed);
		gss_pkg::in_item_t it;
		for (int r = 0; r < rows + 2; r++)
			for (int c = 0; c < cols + 2; c++) begin
				it.first_cell = (r == 0 && c == 0) ? mark : 1'b0;
				it.cell_value = (fixed >= 0) ? ((r + c) % 2 ? 32'h7fffffff : 32'h80000000)
					: rand_value(mode);
				pending_cells.push_back(it);
			end
		grids++;
	endtask

	initial begin
		int total;
		int cols, rows;
		logic [1:0] mode;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = gss_pkg::RegMode;
		cfg_data = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: extremes in heat and nine-point, then mode three on zero sizes
		write_reg(gss_pkg::RegCols, 2);
		write_reg(gss_pkg::RegRows, 2);
		queue_grid(2, 2, 1, gss_pkg::ModeHeat, 1);
		drain();
		write_reg(gss_pkg::RegMode, gss_pkg::ModeNine);
		queue_grid(2, 2, 1, gss_pkg::ModeNine, 1);
		drain();
		write_reg(gss_pkg::RegMode, gss_pkg::ModeThru);
		write_reg(gss_pkg::RegCols, 0);
		write_reg(gss_pkg::RegRows, 0);
		queue_grid(1, 1, 1, gss_pkg::ModeThru, -1);
		queue_grid(1, 1, 0, gss_pkg::ModeThru, -1);
		drain();

		// random grids, mostly small, back to back with or without restart mark
		total = 0;
		while (total < 400) begin
			mode = 2'($urandom_range(0, 3));
			cols = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			rows = $urandom_range(1, 4);
			write_reg(gss_pkg::RegMode, mode);
			write_reg(gss_pkg::RegCols, 11'(cols));
			write_reg(gss_pkg::RegRows, 17'(rows));
			for (int g = $urandom_range(1, 3); g > 0; g--) begin
				queue_grid(cols, rows, $urandom_range(0, 1), mode, -1);
				total += (cols + 2) * (rows + 2);
			end
			drain();
		end
		run_active = 0;
		drain();
		$display("ran %0d grids, checked %0d updated cells across all modes", grids, checked);
		if (errors == 0 && expected_cells.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
